// ----- rtl/core/lhp_pkg.sv -----
package lhp_pkg;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] sample_ns;
    logic [19:0] percentile_ppm;
  } lhp_req_t;

  typedef struct packed {
    logic [4:0]  bucket_index;
    logic [15:0] percentile_upper_us;
    logic [31:0] sample_total;
    logic [63:0] latency_sum_ns;
  } lhp_rsp_t;

  localparam logic [1:0] MODE_ADD   = 2'd0;
  localparam logic [1:0] MODE_QUERY = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam int BOUND_LEN = 28;

  localparam logic [15:0] BOUND_US [BOUND_LEN] = '{
    16'd1,    16'd2,    16'd3,    16'd4,    16'd5,     16'd8,     16'd10,
    16'd15,   16'd20,   16'd30,   16'd40,   16'd50,    16'd75,    16'd100,
    16'd150,  16'd200,  16'd300,  16'd500,  16'd750,   16'd1000,  16'd1500,
    16'd2000, 16'd3000, 16'd5000, 16'd8000, 16'd10000, 16'd20000, 16'd50000
  };

  localparam logic [19:0] PPM_SCALE = 20'd1000000;
  localparam logic [9:0]  NS_PER_US = 10'd1000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIND,
    ST_INC,
    ST_PLO,
    ST_PHI,
    ST_PACC,
    ST_QRD,
    ST_QLO,
    ST_QHI,
    ST_QADD,
    ST_QCMP,
    ST_EMIT
  } lhp_state_t;

  // buckets past the end of the table reuse the last bound
  function automatic logic [15:0] bound_us(input logic [5:0] i);
    logic [15:0] b;
    if (i < 6'(BOUND_LEN)) begin
      b = BOUND_US[i[4:0]];
    end else begin
      b = BOUND_US[BOUND_LEN-1];
    end
    return b;
  endfunction

  function automatic logic [25:0] bound_ns(input logic [5:0] i);
    return 26'(bound_us(i)) * 26'(NS_PER_US);
  endfunction

endpackage

// ----- rtl/core/latency_histogram_percentile.sv -----
// Latency histogram monitor.
// req carries one command per transfer: add a latency sample, query a
// percentile, or clear the histogram. rsp returns exactly one result per
// command, in order, with the bucket touched by an add, the bound answering
// a query, and the sample count and wrapping latency sum after the command.
// Commands run one at a time; req_ready is high only between commands.
// Add: the sample is compared against one bucket bound per cycle, from
// bucket 0 up to the chosen bucket (0 .. NUM_BUCKETS-1). Query: the
// cumulative count is scaled by one shared 32x20 multiplier, two partial
// products per bucket; an empty histogram answers without the walk. Clear
// and the unused mode go straight to the result.
// The result sits in an output register: the next command is taken while it
// waits, and only the following completion stalls until rsp_ready.
// Reset empties every bucket at once through per-bucket valid bits, and
// zeroes the count and the sum; no clearing pass is needed.
module latency_histogram_percentile
  import lhp_pkg::*;
#(
  parameter int NUM_BUCKETS   = 28,
  parameter int COUNTER_WIDTH = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  lhp_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output lhp_rsp_t rsp
);

  localparam int IW = $clog2(NUM_BUCKETS);
  localparam int AW = 84 + $clog2(NUM_BUCKETS) + 1;
  localparam logic [AW-1:0] SAT_SCALED = AW'(64'hFFFF_FFFF_FFFF_FFFF) * AW'(PPM_SCALE);
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_BUCKETS - 1);

  lhp_state_t state, state_next;

  logic [IW-1:0]            idx, idx_next;
  logic [63:0]              ns_q, ns_q_next;
  logic [19:0]              ppm_q, ppm_q_next;
  logic [51:0]              prod, prod_next;
  logic [AW-1:0]            acc, acc_next;
  logic [AW-1:0]            tgt, tgt_next;
  logic                     unreach, unreach_next;
  logic [31:0]              cnt_hi, cnt_hi_next;
  logic [4:0]               bkt, bkt_next;
  logic [15:0]              bound_res, bound_res_next;
  logic [NUM_BUCKETS-1:0]   vld, vld_next;
  logic                     rd_vld;
  logic [COUNTER_WIDTH-1:0] sample_counter, sample_counter_next;
  logic [63:0]              running_sum, running_sum_next;
  logic                     rsp_valid_next;
  lhp_rsp_t                 rsp_next;

  logic [COUNTER_WIDTH-1:0] ram_rdata;
  logic [COUNTER_WIDTH-1:0] cur_count;
  logic [COUNTER_WIDTH-1:0] inc_count;
  logic [63:0]              count64;
  logic [63:0]              cnt64;
  logic [31:0]              mul_a;
  logic [19:0]              mul_b;
  logic                     ram_we;
  logic                     fits;

  lhp_ram #(
    .WIDTH(COUNTER_WIDTH),
    .DEPTH(NUM_BUCKETS)
  ) u_counts (
    .clk  (clk),
    .we   (ram_we),
    .waddr(idx),
    .wdata(inc_count),
    .raddr(idx),
    .rdata(ram_rdata)
  );

  // an entry not written since the last clear reads as zero
  assign cur_count = rd_vld ? ram_rdata : '0;
  assign inc_count = (cur_count == '1) ? cur_count : cur_count + 1'b1;
  assign count64   = 64'(cur_count);
  assign cnt64     = 64'(sample_counter);
  assign fits      = ns_q <= 64'(bound_ns(6'(idx)));
  assign ram_we    = (state == ST_INC);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld            <= '0;
      sample_counter <= '0;
      running_sum    <= '0;
      rsp_valid      <= 1'b0;
    end else begin
      vld            <= vld_next;
      sample_counter <= sample_counter_next;
      running_sum    <= running_sum_next;
      rsp_valid      <= rsp_valid_next;
    end
    idx       <= idx_next;
    ns_q      <= ns_q_next;
    ppm_q     <= ppm_q_next;
    prod      <= prod_next;
    acc       <= acc_next;
    tgt       <= tgt_next;
    unreach   <= unreach_next;
    cnt_hi    <= cnt_hi_next;
    bkt       <= bkt_next;
    bound_res <= bound_res_next;
    rd_vld    <= vld[idx];
    rsp       <= rsp_next;
  end

  always_comb begin
    state_next          = state;
    idx_next            = idx;
    ns_q_next           = ns_q;
    ppm_q_next          = ppm_q;
    prod_next           = prod;
    acc_next            = acc;
    tgt_next            = tgt;
    unreach_next        = unreach;
    cnt_hi_next         = cnt_hi;
    bkt_next            = bkt;
    bound_res_next      = bound_res;
    vld_next            = vld;
    sample_counter_next = sample_counter;
    running_sum_next    = running_sum;
    rsp_valid_next      = rsp_valid && !rsp_ready;
    rsp_next            = rsp;
    req_ready           = 1'b0;
    mul_a               = '0;
    mul_b               = '0;

    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          ns_q_next      = req.sample_ns;
          ppm_q_next     = req.percentile_ppm;
          idx_next       = '0;
          acc_next       = '0;
          bkt_next       = '0;
          bound_res_next = '0;
          case (req.mode)
            MODE_ADD: begin
              state_next = ST_FIND;
            end
            MODE_QUERY: begin
              if (sample_counter == '0) begin
                state_next = ST_EMIT;
              end else begin
                state_next = ST_PLO;
              end
            end
            MODE_CLEAR: begin
              vld_next            = '0;
              sample_counter_next = '0;
              running_sum_next    = '0;
              state_next          = ST_EMIT;
            end
            default: begin
              state_next = ST_EMIT;
            end
          endcase
        end
      end

      // ceil(ns / 1000) <= bound is the same as ns <= bound * 1000
      ST_FIND: begin
        if (fits || idx == LAST_IDX) begin
          state_next = ST_INC;
        end else begin
          idx_next = idx + 1'b1;
        end
      end

      ST_INC: begin
        vld_next[idx]    = 1'b1;
        running_sum_next = running_sum + ns_q;
        if (sample_counter != '1) begin
          sample_counter_next = sample_counter + 1'b1;
        end
        bkt_next   = 5'(idx);
        state_next = ST_EMIT;
      end

      // scaled target: count * ppm, compared later against cum * 1e6
      ST_PLO: begin
        mul_a      = cnt64[31:0];
        mul_b      = ppm_q;
        prod_next  = 52'(mul_a) * 52'(mul_b);
        state_next = ST_PHI;
      end

      ST_PHI: begin
        acc_next   = acc + AW'(prod);
        mul_a      = cnt64[63:32];
        mul_b      = ppm_q;
        prod_next  = 52'(mul_a) * 52'(mul_b);
        state_next = ST_PACC;
      end

      ST_PACC: begin
        tgt_next   = acc + (AW'(prod) << 32);
        acc_next   = '0;
        idx_next   = '0;
        state_next = ST_QRD;
      end

      // count read issued here, data arrives next cycle
      ST_QRD: begin
        unreach_next = tgt > SAT_SCALED;
        state_next   = ST_QLO;
      end

      ST_QLO: begin
        mul_a       = count64[31:0];
        mul_b       = PPM_SCALE;
        prod_next   = 52'(mul_a) * 52'(mul_b);
        cnt_hi_next = count64[63:32];
        state_next  = ST_QHI;
      end

      ST_QHI: begin
        acc_next   = acc + AW'(prod);
        mul_a      = cnt_hi;
        mul_b      = PPM_SCALE;
        prod_next  = 52'(mul_a) * 52'(mul_b);
        state_next = ST_QADD;
      end

      ST_QADD: begin
        acc_next   = acc + (AW'(prod) << 32);
        state_next = ST_QCMP;
      end

      ST_QCMP: begin
        if (!unreach && acc >= tgt) begin
          bound_res_next = bound_us(6'(idx));
          state_next     = ST_EMIT;
        end else if (idx == LAST_IDX) begin
          bound_res_next = bound_us(6'(NUM_BUCKETS - 1));
          state_next     = ST_EMIT;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = ST_QRD;
        end
      end

      ST_EMIT: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_next.bucket_index        = bkt;
          rsp_next.percentile_upper_us = bound_res;
          rsp_next.sample_total        = 32'(sample_counter);
          rsp_next.latency_sum_ns      = running_sum;
          rsp_valid_next               = 1'b1;
          state_next                   = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_add_counts: assert property (@(posedge clk) disable iff (rst)
    state == ST_INC |=> sample_counter != '0)
    else $error("sample count still zero after an add");

  a_entry_valid: assert property (@(posedge clk) disable iff (rst)
    state == ST_INC |=> vld[$past(idx)])
    else $error("incremented bucket not marked valid");

  a_hit_emits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_QCMP && !unreach && acc >= tgt) |=> state == ST_EMIT)
    else $error("query hit did not finish the walk");

  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> (vld == '0 && sample_counter == '0 && running_sum == '0))
    else $error("histogram not empty after reset");

endmodule

// ----- rtl/core/lhp_ram.sv -----
module lhp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 28
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- tb/latency_histogram_percentile_tb.sv -----
`timescale 1ns / 1ps

module latency_histogram_percentile_tb;
  import lhp_pkg::*;

  localparam int NBINS = 28;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam logic [15:0] BIN_LIMIT_US [NBINS] = '{
    16'd1,    16'd2,    16'd3,    16'd4,    16'd5,     16'd8,     16'd10,
    16'd15,   16'd20,   16'd30,   16'd40,   16'd50,    16'd75,    16'd100,
    16'd150,  16'd200,  16'd300,  16'd500,  16'd750,   16'd1000,  16'd1500,
    16'd2000, 16'd3000, 16'd5000, 16'd8000, 16'd10000, 16'd20000, 16'd50000
  };

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_ready;
  lhp_req_t req = '0;
  logic     rsp_valid;
  logic     rsp_ready = 1'b0;
  lhp_rsp_t rsp;

  // shadow histogram
  logic [31:0] bin_count [NBINS];
  logic [31:0] total_samples;
  logic [63:0] latency_sum;

  lhp_rsp_t    pending_rsp [$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit          calm = 1'b0;

  latency_histogram_percentile uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("latency_histogram_percentile_tb failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    rsp_ready <= calm || ($urandom_range(99) >= 34);
  end

  function automatic void empty_histogram();
    for (int i = 0; i < NBINS; i++) begin
      bin_count[i] = '0;
    end
    total_samples = '0;
    latency_sum   = '0;
  endfunction

  function automatic lhp_rsp_t histogram_outcome(input lhp_req_t cmd);
    lhp_rsp_t    o;
    logic [63:0] us;
    logic [63:0] target;
    logic [63:0] running;
    int          b;
    bit          found;
    o = '0;
    case (cmd.mode)
      MODE_ADD: begin
        // round up to whole microseconds
        us = cmd.sample_ns / 64'd1000 + 64'((cmd.sample_ns % 64'd1000) != 0);
        b = NBINS - 1;
        for (int i = NBINS - 1; i >= 0; i--) begin
          if (64'(BIN_LIMIT_US[i]) >= us) begin
            b = i;
          end
        end
        latency_sum = latency_sum + cmd.sample_ns;
        if (bin_count[b] != '1) begin
          bin_count[b] = bin_count[b] + 1;
        end
        if (total_samples != '1) begin
          total_samples = total_samples + 1;
        end
        o.bucket_index = 5'(b);
      end
      MODE_QUERY: begin
        if (total_samples != 0) begin
          target = (64'(total_samples) * 64'(cmd.percentile_ppm) + 64'd999999) / 64'd1000000;
          running = '0;
          found = 1'b0;
          o.percentile_upper_us = BIN_LIMIT_US[NBINS-1];
          for (int i = 0; i < NBINS; i++) begin
            running = running + 64'(bin_count[i]);
            if (!found && running >= target) begin
              o.percentile_upper_us = BIN_LIMIT_US[i];
              found = 1'b1;
            end
          end
        end
      end
      MODE_CLEAR: begin
        empty_histogram();
      end
      default: begin
      end
    endcase
    o.sample_total   = total_samples;
    o.latency_sum_ns = latency_sum;
    return o;
  endfunction

  always @(posedge clk) begin
    lhp_rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_rsp.size() == 0) begin
        $error("result with nothing outstanding: %p", rsp);
        mismatches++;
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.bucket_index !== want.bucket_index) begin
          $error("bucket_index expected %0d got %0d", want.bucket_index, rsp.bucket_index);
          mismatches++;
        end
        if (rsp.percentile_upper_us !== want.percentile_upper_us) begin
          $error("percentile_upper_us expected %0d got %0d",
                 want.percentile_upper_us, rsp.percentile_upper_us);
          mismatches++;
        end
        if (rsp.sample_total !== want.sample_total) begin
          $error("sample_total expected %0d got %0d", want.sample_total, rsp.sample_total);
          mismatches++;
        end
        if (rsp.latency_sum_ns !== want.latency_sum_ns) begin
          $error("latency_sum_ns expected %0h got %0h", want.latency_sum_ns, rsp.latency_sum_ns);
          mismatches++;
        end
      end
    end
  end

  // one command transfer; the expectation is formed at the accepting edge
  task automatic send_cmd(input lhp_req_t cmd);
    while (!calm && $urandom_range(99) < 34) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= cmd;
    @(posedge clk);
    while (!req_ready) begin
      @(posedge clk);
    end
    pending_rsp.push_back(histogram_outcome(cmd));
  endtask

  function automatic lhp_req_t make_cmd(input logic [1:0] mode, input logic [63:0] ns,
                                        input logic [19:0] ppm);
    lhp_req_t c;
    c.mode           = mode;
    c.sample_ns      = ns;
    c.percentile_ppm = ppm;
    return c;
  endfunction

  function automatic logic [63:0] pick_latency();
    int unsigned sel;
    logic [63:0] edge_ns;
    sel = $urandom_range(99);
    if (sel < 50) begin
      // straddle a bucket bound by one nanosecond either way
      edge_ns = 64'(BIN_LIMIT_US[$urandom_range(NBINS - 1)]) * 64'd1000;
      return edge_ns - 64'd1 + 64'($urandom_range(2));
    end else if (sel < 80) begin
      return 64'($urandom_range(60000000));
    end
    return {$urandom, $urandom};
  endfunction

  function automatic logic [19:0] pick_ppm();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 70) begin
      return 20'($urandom_range(1000000));
    end else if (sel < 90) begin
      case ($urandom_range(4))
        0: return 20'd0;
        1: return 20'd500000;
        2: return 20'd990000;
        3: return 20'd999999;
        default: return 20'd1000000;
      endcase
    end
    return 20'($urandom);
  endfunction

  task automatic test_empty_histogram();
    send_cmd(make_cmd(MODE_QUERY, {$urandom, $urandom}, 20'd500000));
    send_cmd(make_cmd(MODE_SPARE, '1, '1));
  endtask

  task automatic test_bucket_edges();
    send_cmd(make_cmd(MODE_ADD, 64'd0, 20'd0));
    send_cmd(make_cmd(MODE_ADD, 64'd1, '1));
    send_cmd(make_cmd(MODE_ADD, 64'd1000, 20'd0));
    send_cmd(make_cmd(MODE_ADD, 64'd1001, 20'd0));
    send_cmd(make_cmd(MODE_ADD, 64'd3001, 20'd0));
    send_cmd(make_cmd(MODE_ADD, 64'd750000, 20'd0));
    send_cmd(make_cmd(MODE_ADD, 64'd750001, 20'd0));
    send_cmd(make_cmd(MODE_ADD, 64'd50000000, 20'd0));
    // past the last bound, then a sum that wraps
    send_cmd(make_cmd(MODE_ADD, 64'd50000001, 20'd0));
    send_cmd(make_cmd(MODE_ADD, '1, 20'd0));
  endtask

  task automatic test_query_edges();
    send_cmd(make_cmd(MODE_QUERY, '1, 20'd0));
    send_cmd(make_cmd(MODE_QUERY, 64'd0, 20'd1));
    send_cmd(make_cmd(MODE_QUERY, 64'd0, 20'd500000));
    send_cmd(make_cmd(MODE_QUERY, 64'd0, 20'd999999));
    send_cmd(make_cmd(MODE_QUERY, 64'd0, 20'd1000000));
    // above a million: target out of reach
    send_cmd(make_cmd(MODE_QUERY, 64'd0, '1));
  endtask

  task automatic test_clear();
    send_cmd(make_cmd(MODE_SPARE, 64'd0, 20'd0));
    send_cmd(make_cmd(MODE_CLEAR, '1, '1));
    send_cmd(make_cmd(MODE_QUERY, 64'd0, 20'd1000000));
  endtask

  task automatic test_random_mix(input int unsigned count);
    int unsigned sel;
    for (int unsigned n = 0; n < count; n++) begin
      calm = (n >= count / 3) && (n < count / 2);
      sel = $urandom_range(99);
      if (sel < 65) begin
        send_cmd(make_cmd(MODE_ADD, pick_latency(), 20'($urandom)));
      end else if (sel < 93) begin
        send_cmd(make_cmd(MODE_QUERY, {$urandom, $urandom}, pick_ppm()));
      end else if (sel < 97) begin
        send_cmd(make_cmd(MODE_SPARE, {$urandom, $urandom}, 20'($urandom)));
      end else begin
        send_cmd(make_cmd(MODE_CLEAR, {$urandom, $urandom}, 20'($urandom)));
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    empty_histogram();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_histogram();
    test_bucket_edges();
    test_query_edges();
    test_clear();
    test_random_mix(600);

    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("latency_histogram_percentile_tb passed");
    end else begin
      $display("latency_histogram_percentile_tb failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/lhp_pkg.sv
rtl/core/lhp_ram.sv
rtl/core/latency_histogram_percentile.sv
tb/latency_histogram_percentile_tb.sv
